FILE: rtl/core/rab_pkg.sv
// Package for the range and bearing block: shared widths, constants,
// the status flags carried down the pipeline and the arctangent table.
// No dependencies.
package rab_pkg;

    localparam int RANGE_W   = 25;
    localparam int BEARING_W = 16;
    localparam int ANG_W     = 32;
    localparam int CORDIC_W  = 64;
    localparam int PROD_W    = ANG_W + BEARING_W;

    localparam logic [RANGE_W-1:0]   RANGE_MAX    = 25'h1FF_FFFF;
    localparam logic [BEARING_W-1:0] BEARING_TURN = 16'd46080;
    localparam logic [ANG_W-1:0]     HALF_TURN    = 32'h8000_0000;

    // Signs of the offsets and the equal-positions mark.
    typedef struct packed {
        logic dx_neg;
        logic dy_neg;
        logic zero;
    } rab_flags_t;

    // atan(2^-i) as a binary angle where 2^32 is a full turn.
    function automatic logic [ANG_W-1:0] rab_atan(input logic [4:0] i);
        logic [ANG_W-1:0] a;
        case (i)
            5'd0:    a = 32'd536870912;
            5'd1:    a = 32'd316933406;
            5'd2:    a = 32'd167458907;
            5'd3:    a = 32'd85004756;
            5'd4:    a = 32'd42667331;
            5'd5:    a = 32'd21354465;
            5'd6:    a = 32'd10679838;
            5'd7:    a = 32'd5340245;
            5'd8:    a = 32'd2670163;
            5'd9:    a = 32'd1335087;
            5'd10:   a = 32'd667544;
            5'd11:   a = 32'd333772;
            5'd12:   a = 32'd166886;
            5'd13:   a = 32'd83443;
            5'd14:   a = 32'd41722;
            5'd15:   a = 32'd20861;
            5'd16:   a = 32'd10430;
            5'd17:   a = 32'd5215;
            5'd18:   a = 32'd2608;
            5'd19:   a = 32'd1304;
            5'd20:   a = 32'd652;
            5'd21:   a = 32'd326;
            5'd22:   a = 32'd163;
            5'd23:   a = 32'd81;
            5'd24:   a = 32'd41;
            5'd25:   a = 32'd20;
            5'd26:   a = 32'd10;
            5'd27:   a = 32'd5;
            5'd28:   a = 32'd3;
            5'd29:   a = 32'd1;
            5'd30:   a = 32'd1;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

endpackage

FILE: rtl/core/rab_if.sv
// Channel interfaces of the range and bearing block: the position pair
// going in and the range and bearing result coming out. Uses rab_pkg.
interface rab_pair_if #(parameter int COORD_BITS = 24) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] own_x;
    logic signed [COORD_BITS-1:0] own_y;
    logic signed [COORD_BITS-1:0] target_x;
    logic signed [COORD_BITS-1:0] target_y;

    modport source (output valid, own_x, own_y, target_x, target_y, input ready);
    modport sink   (input valid, own_x, own_y, target_x, target_y, output ready);
endinterface

interface rab_result_if import rab_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [RANGE_W-1:0]   range_out;
    logic [BEARING_W-1:0] bearing_out;

    modport source (output valid, range_out, bearing_out, input ready);
    modport sink   (input valid, range_out, bearing_out, output ready);
endinterface

FILE: rtl/core/rab_iter_stage.sv
// One stage of the range and bearing pipeline: one digit of the square
// root and one CORDIC vectoring rotation, each where the stage has one.
// Uses rab_pkg.
module rab_iter_stage
    import rab_pkg::*;
#(
    parameter int COORD_BITS   = 24,
    parameter int CORDIC_STEPS = 20,
    parameter int STAGE        = 0
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  rab_flags_t                       in_flags,
    input  logic [2*(COORD_BITS+1)-1:0]      in_n,
    input  logic [COORD_BITS:0]              in_root,
    input  logic [COORD_BITS+2:0]            in_rem,
    input  logic signed [CORDIC_W-1:0]       in_x,
    input  logic signed [CORDIC_W-1:0]       in_y,
    input  logic [ANG_W-1:0]                 in_z,
    output logic                             out_valid,
    input  logic                             out_ready,
    output rab_flags_t                       out_flags,
    output logic [2*(COORD_BITS+1)-1:0]      out_n,
    output logic [COORD_BITS:0]              out_root,
    output logic [COORD_BITS+2:0]            out_rem,
    output logic signed [CORDIC_W-1:0]       out_x,
    output logic signed [CORDIC_W-1:0]       out_y,
    output logic [ANG_W-1:0]                 out_z
);

    localparam int ROOT_BITS = COORD_BITS + 1;
    localparam int NW        = 2 * ROOT_BITS;
    localparam int REM_W     = ROOT_BITS + 2;

    logic                        valid_reg;
    rab_flags_t                  flags_reg;
    logic [NW-1:0]               n_reg;
    logic [ROOT_BITS-1:0]        root_reg, root_next;
    logic [REM_W-1:0]            rem_reg, rem_next;
    logic signed [CORDIC_W-1:0]  x_reg, x_next;
    logic signed [CORDIC_W-1:0]  y_reg, y_next;
    logic [ANG_W-1:0]            z_reg, z_next;

    assign in_ready = !valid_reg || out_ready;

    generate
        if (STAGE < ROOT_BITS) begin : g_root
            logic [1:0]       pair;
            logic [REM_W-1:0] rem_sh;
            logic [REM_W-1:0] trial;

            // Digit pairs are taken from the top of the radicand downwards.
            assign pair   = in_n[NW-1-2*STAGE -: 2];
            assign rem_sh = {in_rem[REM_W-3:0], pair};
            assign trial  = {in_root, 2'b01};

            always_comb
            begin
                if (rem_sh >= trial)
                begin
                    rem_next  = rem_sh - trial;
                    root_next = {in_root[ROOT_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh;
                    root_next = {in_root[ROOT_BITS-2:0], 1'b0};
                end
            end
        end
        else begin : g_root_pass
            assign rem_next  = in_rem;
            assign root_next = in_root;
        end

        if (STAGE < CORDIC_STEPS) begin : g_rot
            logic signed [CORDIC_W-1:0] xs;
            logic signed [CORDIC_W-1:0] ys;
            logic [ANG_W-1:0]           step_ang;

            // Arithmetic shifts round towards minus infinity.
            assign xs       = in_x >>> STAGE;
            assign ys       = in_y >>> STAGE;
            assign step_ang = rab_atan(5'(STAGE));

            always_comb
            begin
                if (!in_y[CORDIC_W-1])
                begin
                    x_next = in_x + ys;
                    y_next = in_y - xs;
                    z_next = in_z + step_ang;
                end
                else
                begin
                    x_next = in_x - ys;
                    y_next = in_y + xs;
                    z_next = in_z - step_ang;
                end
            end
        end
        else begin : g_rot_pass
            assign x_next = in_x;
            assign y_next = in_y;
            assign z_next = in_z;
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            flags_reg <= in_flags;
            n_reg     <= in_n;
            root_reg  <= root_next;
            rem_reg   <= rem_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            z_reg     <= z_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_flags = flags_reg;
    assign out_n     = n_reg;
    assign out_root  = root_reg;
    assign out_rem   = rem_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;

endmodule

FILE: rtl/core/range_and_bearing.sv
// Range and bearing between two positions: a pipeline of digit and
// CORDIC stages built from rab_iter_stage. Uses rab_pkg and rab_if.
//
// The block takes one position pair per clock cycle while no output stall
// holds it back and returns, for each, the rounded distance in 1/64 metre
// and the clockwise bearing from north in 1/128 degree (0 to 46079; equal
// positions give bearing 0). Stages a to d form the offsets, magnitudes,
// squares and their sum, then each iteration stage resolves one bit of the
// exact square root and, while its index is below CORDIC_STEPS, one CORDIC
// rotation; stage e and the output register finish rounding and the
// bearing scale. The length of the square root, one bit per stage, sets
// the depth at the default settings. Every stage has its own valid bit and
// moves on whenever the stage after it has room, so bubbles are squeezed
// out during an output stall and nothing is lost or repeated.
module range_and_bearing
    import rab_pkg::*;
#(
    parameter int COORD_BITS   = 24,
    parameter int CORDIC_STEPS = 20
) (
    input  logic          clk,
    input  logic          rst_n,
    rab_pair_if.sink      pair,
    rab_result_if.source  result
);

    localparam int DW        = COORD_BITS + 1;
    localparam int ROOT_BITS = COORD_BITS + 1;
    localparam int NW        = 2 * ROOT_BITS;
    localparam int REM_W     = ROOT_BITS + 2;
    localparam int SQ_W      = 2 * COORD_BITS;
    localparam int GUARD     = 61 - COORD_BITS;
    localparam int NSTEP     = (ROOT_BITS > CORDIC_STEPS) ? ROOT_BITS : CORDIC_STEPS;
    localparam int RND_W     = ROOT_BITS + 1;
    localparam int CMP_W     = (RND_W > RANGE_W) ? RND_W : RANGE_W;

    // Stage a: coordinate offsets.
    logic                 a_valid_reg;
    logic                 ready_a;
    logic signed [DW-1:0] dx_a_reg, dx_a_next;
    logic signed [DW-1:0] dy_a_reg, dy_a_next;

    // Stage b: magnitudes and signs.
    logic                  b_valid_reg;
    logic                  ready_b;
    logic [COORD_BITS-1:0] ax_b_reg, ax_b_next;
    logic [COORD_BITS-1:0] ay_b_reg, ay_b_next;
    rab_flags_t            flags_b_reg, flags_b_next;

    // Stage c: squares.
    logic                  c_valid_reg;
    logic                  ready_c;
    logic [COORD_BITS-1:0] ax_c_reg;
    logic [COORD_BITS-1:0] ay_c_reg;
    logic [SQ_W-1:0]       sx_c_reg, sx_c_next;
    logic [SQ_W-1:0]       sy_c_reg, sy_c_next;
    rab_flags_t            flags_c_reg;

    // Stage d: radicand and CORDIC start vector.
    logic                       d_valid_reg;
    logic                       ready_d;
    logic [NW-1:0]              n_d_reg, n_d_next;
    logic signed [CORDIC_W-1:0] x_d_reg, x_d_next;
    logic signed [CORDIC_W-1:0] y_d_reg, y_d_next;
    rab_flags_t                 flags_d_reg;

    // Iteration chain; index 0 is fed by stage d.
    logic                       it_valid [NSTEP+1];
    logic                       it_ready [NSTEP+1];
    rab_flags_t                 it_flags [NSTEP+1];
    logic [NW-1:0]              it_n     [NSTEP+1];
    logic [ROOT_BITS-1:0]       it_root  [NSTEP+1];
    logic [REM_W-1:0]           it_rem   [NSTEP+1];
    logic signed [CORDIC_W-1:0] it_x     [NSTEP+1];
    logic signed [CORDIC_W-1:0] it_y     [NSTEP+1];
    logic [ANG_W-1:0]           it_z     [NSTEP+1];

    // Stage e: rounded range and scaled angle.
    logic                 e_valid_reg;
    logic                 ready_e;
    logic [RANGE_W-1:0]   range_e_reg, range_e_next;
    logic [PROD_W-1:0]    prod_e_reg, prod_e_next;
    logic                 zero_e_reg;
    logic [RND_W-1:0]     rounded;
    logic [CMP_W-1:0]     rounded_ext;
    logic [ANG_W-1:0]     ang;
    rab_flags_t           fin_flags;

    // Output register.
    logic                 o_valid_reg;
    logic                 ready_o;
    logic [RANGE_W-1:0]   range_o_reg;
    logic [BEARING_W-1:0] bearing_o_reg, bearing_o_next;
    logic [PROD_W-1:0]    prod_rnd;
    logic [BEARING_W-1:0] bearing_raw;

    assign ready_o = !o_valid_reg || result.ready;
    assign ready_e = !e_valid_reg || ready_o;
    assign ready_d = !d_valid_reg || it_ready[0];
    assign ready_c = !c_valid_reg || ready_d;
    assign ready_b = !b_valid_reg || ready_c;
    assign ready_a = !a_valid_reg || ready_b;
    assign pair.ready = ready_a;

    // ---------------- stage a ----------------
    assign dx_a_next = {pair.target_x[COORD_BITS-1], pair.target_x}
                     - {pair.own_x[COORD_BITS-1], pair.own_x};
    assign dy_a_next = {pair.target_y[COORD_BITS-1], pair.target_y}
                     - {pair.own_y[COORD_BITS-1], pair.own_y};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (ready_a)
        begin
            a_valid_reg <= pair.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_a && pair.valid)
        begin
            dx_a_reg <= dx_a_next;
            dy_a_reg <= dy_a_next;
        end
    end

    // ---------------- stage b ----------------
    // An offset never exceeds 2^COORD_BITS - 1 in size, so the magnitude
    // fits in COORD_BITS bits.
    always_comb
    begin
        logic signed [DW-1:0] ndx;
        logic signed [DW-1:0] ndy;
        ndx = -dx_a_reg;
        ndy = -dy_a_reg;
        ax_b_next = dx_a_reg[DW-1] ? ndx[COORD_BITS-1:0] : dx_a_reg[COORD_BITS-1:0];
        ay_b_next = dy_a_reg[DW-1] ? ndy[COORD_BITS-1:0] : dy_a_reg[COORD_BITS-1:0];
        flags_b_next.dx_neg = dx_a_reg[DW-1];
        flags_b_next.dy_neg = dy_a_reg[DW-1];
        flags_b_next.zero   = (dx_a_reg == '0) && (dy_a_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (ready_b)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_b && a_valid_reg)
        begin
            ax_b_reg    <= ax_b_next;
            ay_b_reg    <= ay_b_next;
            flags_b_reg <= flags_b_next;
        end
    end

    // ---------------- stage c ----------------
    assign sx_c_next = SQ_W'(ax_b_reg) * SQ_W'(ax_b_reg);
    assign sy_c_next = SQ_W'(ay_b_reg) * SQ_W'(ay_b_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (ready_c)
        begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_c && b_valid_reg)
        begin
            ax_c_reg    <= ax_b_reg;
            ay_c_reg    <= ay_b_reg;
            sx_c_reg    <= sx_c_next;
            sy_c_reg    <= sy_c_next;
            flags_c_reg <= flags_b_reg;
        end
    end

    // ---------------- stage d ----------------
    // The CORDIC vector is (north, east), scaled up into the guard bits.
    assign n_d_next = NW'(sx_c_reg) + NW'(sy_c_reg);
    assign x_d_next = CORDIC_W'(ay_c_reg) << GUARD;
    assign y_d_next = CORDIC_W'(ax_c_reg) << GUARD;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
        end
        else if (ready_d)
        begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_d && c_valid_reg)
        begin
            n_d_reg     <= n_d_next;
            x_d_reg     <= x_d_next;
            y_d_reg     <= y_d_next;
            flags_d_reg <= flags_c_reg;
        end
    end

    assign it_valid[0] = d_valid_reg;
    assign it_flags[0] = flags_d_reg;
    assign it_n[0]     = n_d_reg;
    assign it_root[0]  = '0;
    assign it_rem[0]   = '0;
    assign it_x[0]     = x_d_reg;
    assign it_y[0]     = y_d_reg;
    assign it_z[0]     = '0;

    // ---------------- iteration stages ----------------
    generate
        for (genvar k = 0; k < NSTEP; k++) begin : g_iter
            rab_iter_stage #(
                .COORD_BITS   (COORD_BITS),
                .CORDIC_STEPS (CORDIC_STEPS),
                .STAGE        (k)
            ) u_stage (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (it_valid[k]),
                .in_ready  (it_ready[k]),
                .in_flags  (it_flags[k]),
                .in_n      (it_n[k]),
                .in_root   (it_root[k]),
                .in_rem    (it_rem[k]),
                .in_x      (it_x[k]),
                .in_y      (it_y[k]),
                .in_z      (it_z[k]),
                .out_valid (it_valid[k+1]),
                .out_ready (it_ready[k+1]),
                .out_flags (it_flags[k+1]),
                .out_n     (it_n[k+1]),
                .out_root  (it_root[k+1]),
                .out_rem   (it_rem[k+1]),
                .out_x     (it_x[k+1]),
                .out_y     (it_y[k+1]),
                .out_z     (it_z[k+1])
            );
        end
    endgenerate

    assign it_ready[NSTEP] = ready_e;

    // ---------------- stage e ----------------
    // Round to nearest: step up when the remainder exceeds the root.
    assign fin_flags   = it_flags[NSTEP];
    assign rounded     = RND_W'(it_root[NSTEP])
                       + RND_W'(it_rem[NSTEP] > REM_W'(it_root[NSTEP]));
    assign rounded_ext = CMP_W'(rounded);
    assign range_e_next = (rounded_ext > CMP_W'(RANGE_MAX)) ? RANGE_MAX
                                                            : rounded_ext[RANGE_W-1:0];

    // Fold the first-quadrant angle into the quadrant of the offset.
    always_comb
    begin
        case ({fin_flags.dx_neg, fin_flags.dy_neg})
            2'b00:   ang = it_z[NSTEP];
            2'b01:   ang = HALF_TURN - it_z[NSTEP];
            2'b11:   ang = HALF_TURN + it_z[NSTEP];
            default: ang = '0 - it_z[NSTEP];
        endcase
    end

    assign prod_e_next = PROD_W'(ang) * PROD_W'(BEARING_TURN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
        end
        else if (ready_e)
        begin
            e_valid_reg <= it_valid[NSTEP];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_e && it_valid[NSTEP])
        begin
            range_e_reg <= range_e_next;
            prod_e_reg  <= prod_e_next;
            zero_e_reg  <= fin_flags.zero;
        end
    end

    // ---------------- output register ----------------
    assign prod_rnd    = prod_e_reg + PROD_W'(HALF_TURN);
    assign bearing_raw = prod_rnd[PROD_W-1:ANG_W];
    assign bearing_o_next = (zero_e_reg || bearing_raw >= BEARING_TURN) ? '0 : bearing_raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (ready_o)
        begin
            o_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_o && e_valid_reg)
        begin
            range_o_reg   <= range_e_reg;
            bearing_o_reg <= bearing_o_next;
        end
    end

    assign result.valid       = o_valid_reg;
    assign result.range_out   = range_o_reg;
    assign result.bearing_out = bearing_o_reg;

    // ---------------- assertions ----------------
    // A zero range only comes from equal positions, whose bearing is zero.
    a_zero_range_bearing: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && (result.range_out == '0) |-> (result.bearing_out == '0))
        else $error("zero range with a non-zero bearing");

    a_bearing_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.bearing_out < BEARING_TURN))
        else $error("bearing not wrapped below a full turn");

    // The equal-positions flag and the root must agree after rounding.
    a_zero_flag_root: assert property (@(posedge clk) disable iff (!rst_n)
        e_valid_reg |-> (zero_e_reg == (range_e_reg == '0)))
        else $error("equal-positions flag disagrees with the range");

    // Stage a, on accepting a valid position pair, shows a valid item next.
    a_entry_advance: assert property (@(posedge clk) disable iff (!rst_n)
        pair.valid && pair.ready |=> a_valid_reg)
        else $error("accepted transaction did not enter the pipeline");

endmodule
